>>> hw/rtl/crr_pkg.sv
// ----------------------------------------------------------------------------
// crr_pkg
// shared constants, types and helpers of the card report receiver
// ----------------------------------------------------------------------------
package crr_pkg;

    localparam int CARD_BYTES   = 80;
    localparam int BLOCK_CARDS  = 23;
    localparam int POS_W        = $clog2(CARD_BYTES);

    localparam logic [15:0] INIT_EXPECTED = 16'd1;
    localparam logic [15:0] INIT_REQUEST  = 16'd47;
    localparam int          BLOCK_OFFSET  = 24;
    localparam logic [15:0] SEQ_MAX       = 16'hFFFF;

    // quotient by reciprocal multiply, exact for all 16-bit dividends
    localparam int DIV_SHIFT = 24;
    localparam int DIV_MW    = DIV_SHIFT + 1;
    localparam logic [DIV_MW-1:0] DIV_MULT =
        DIV_MW'(((2 ** DIV_SHIFT) + BLOCK_CARDS - 1) / BLOCK_CARDS);
    localparam int BLK_W = 8;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_INIT    = 2'd1;
    localparam logic [1:0] OP_REQUEST = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [16:0] VALUE_SAT = 17'h10000;

    typedef struct packed {
        logic        done;
        logic        header_ok;
        logic [7:0]  kind;
        logic        num_ok;
        logic [15:0] num;
    } card_info_t;

    typedef struct packed {
        logic        card_done;
        logic        card_good;
        logic [7:0]  card_kind;
        logic [15:0] expected_card;
        logic [15:0] request_number;
        logic        request_taken;
    } result_t;

    function automatic logic [7:0] header_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CH_O;
            default: ch = CH_F;
        endcase
        return ch;
    endfunction

endpackage

>>> hw/rtl/crr_parser.sv
// ----------------------------------------------------------------------------
// crr_parser
// per-byte card checker: header match, type byte capture and number parse
// ----------------------------------------------------------------------------
module crr_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_accept,
    input  logic [1:0]         op,
    input  logic [7:0]         data_byte,
    input  logic               card_clear,
    output crr_pkg::card_info_t info
);
    import crr_pkg::*;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             header_reg, header_next;
    logic [7:0]       kind_reg, kind_next;
    phase_t           phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [16:0]      value_reg, value_next;

    logic        is_byte;
    logic        last;
    logic        digit;
    logic [20:0] scaled;
    logic [16:0] value_step;

    assign is_byte = item_accept && (op == OP_BYTE);
    assign last    = (pos_reg == POS_W'(CARD_BYTES - 1));
    assign digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign scaled  = ({4'b0, value_reg} << 3) + ({4'b0, value_reg} << 1)
                   + {17'b0, data_byte[3:0]};
    assign value_step = (scaled > {4'b0, VALUE_SAT}) ? VALUE_SAT : scaled[16:0];

    always_comb
    begin
        header_next = header_reg;
        kind_next   = kind_reg;
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        if (is_byte)
        begin
            pos_next = last ? '0 : pos_reg + POS_W'(1);
            if (pos_reg < POS_W'(3))
            begin
                if (data_byte != header_char(pos_reg[1:0]))
                begin
                    header_next = 1'b0;
                end
            end
            else if (pos_reg == POS_W'(3))
            begin
                kind_next = data_byte;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SKIP:
                    begin
                        if (data_byte == CH_SPACE)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else if ((data_byte == CH_PLUS) || (data_byte == CH_MINUS))
                        begin
                            neg_next   = (data_byte == CH_MINUS);
                            phase_next = PH_DIGITS;
                        end
                        else if (digit)
                        begin
                            value_next = value_step;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (digit)
                        begin
                            value_next = value_step;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    assign info.done      = is_byte && last;
    assign info.header_ok = header_next;
    assign info.kind      = kind_next;
    assign info.num_ok    = !value_next[16] && !(neg_next && (|value_next[15:0]));
    assign info.num       = value_next[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            header_reg <= 1'b1;
            kind_reg   <= CH_NUL;
            phase_reg  <= PH_SKIP;
            neg_reg    <= 1'b0;
            value_reg  <= '0;
        end
        else if (info.done || card_clear)
        begin
            pos_reg    <= '0;
            header_reg <= 1'b1;
            kind_reg   <= CH_NUL;
            phase_reg  <= PH_SKIP;
            neg_reg    <= 1'b0;
            value_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            header_reg <= header_next;
            kind_reg   <= kind_next;
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            value_reg  <= value_next;
        end
    end

endmodule

>>> hw/rtl/crr_seq.sv
// ----------------------------------------------------------------------------
// crr_seq
// expected card number, pending request and block advance
// ----------------------------------------------------------------------------
module crr_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_accept,
    input  logic [1:0]          op,
    input  logic                report_complete,
    input  crr_pkg::card_info_t info,
    output logic                card_clear,
    output logic                quot_ok,
    output crr_pkg::result_t    result
);
    import crr_pkg::*;

    logic [15:0] expected_reg, expected_next;
    logic [15:0] pending_reg, pending_next;
    logic        good_seen_reg, good_seen_next;
    logic        since_init_reg, since_init_next;
    logic [15:0] quot_reg;
    logic        quot_ok_reg;

    logic                     kind_ok;
    logic                     good;
    logic                     pend_above;
    logic                     taken;
    logic [DIV_MW+15:0]       quot_prod;
    logic [16:0]              quot_inc;
    logic [BLK_W+16:0]        block_sum;
    logic [15:0]              block_next;

    assign kind_ok = (info.kind == CH_A) || (info.kind == CH_C) ||
                     (info.kind == CH_D) || (info.kind == CH_E) ||
                     (info.kind == CH_NUL);
    assign good = info.header_ok && kind_ok && info.num_ok &&
                  (info.num == expected_reg);
    assign pend_above = pending_reg > expected_reg;
    assign taken = item_accept && (op == OP_REQUEST) && since_init_reg &&
                   !report_complete;

    assign quot_prod  = {{DIV_MW{1'b0}}, pending_reg} * {16'b0, DIV_MULT};
    assign quot_inc   = {1'b0, quot_reg} + 17'd1;
    assign block_sum  = ({{BLK_W{1'b0}}, quot_inc} * (BLK_W + 17)'(BLOCK_CARDS))
                      + (BLK_W + 17)'(BLOCK_OFFSET);
    assign block_next = (block_sum > {{(BLK_W + 1){1'b0}}, SEQ_MAX}) ?
                        SEQ_MAX : block_sum[15:0];

    always_comb
    begin
        expected_next   = expected_reg;
        pending_next    = pending_reg;
        good_seen_next  = good_seen_reg;
        since_init_next = since_init_reg;
        if (item_accept)
        begin
            unique case (op)
                OP_BYTE:
                begin
                    if (info.done)
                    begin
                        since_init_next = 1'b1;
                        if (good)
                        begin
                            if ((info.kind == CH_E) && pend_above)
                            begin
                                pending_next = expected_reg + 16'd1;
                            end
                            if (expected_reg != SEQ_MAX)
                            begin
                                expected_next = expected_reg + 16'd1;
                            end
                            good_seen_next = 1'b1;
                        end
                        else if (pend_above)
                        begin
                            pending_next = (good_seen_reg && (expected_reg != 16'd0)) ?
                                           expected_reg - 16'd1 : expected_reg;
                        end
                    end
                end
                OP_INIT:
                begin
                    expected_next   = INIT_EXPECTED;
                    pending_next    = INIT_REQUEST;
                    since_init_next = 1'b0;
                end
                OP_REQUEST:
                begin
                    if (taken)
                    begin
                        expected_next  = pending_reg;
                        pending_next   = block_next;
                        good_seen_next = 1'b0;
                    end
                end
                default:
                begin
                    expected_next = expected_reg;
                end
            endcase
        end
    end

    assign card_clear = item_accept && ((op == OP_INIT) || taken);
    assign quot_ok    = quot_ok_reg;

    assign result.card_done      = info.done;
    assign result.card_good      = info.done && good;
    assign result.card_kind      = info.done ? info.kind : CH_NUL;
    assign result.expected_card  = expected_next;
    assign result.request_number = pending_next;
    assign result.request_taken  = taken;

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_prod[DIV_SHIFT +: 16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg   <= INIT_EXPECTED;
            pending_reg    <= INIT_REQUEST;
            good_seen_reg  <= 1'b0;
            since_init_reg <= 1'b0;
            quot_ok_reg    <= 1'b0;
        end
        else
        begin
            expected_reg   <= expected_next;
            pending_reg    <= pending_next;
            good_seen_reg  <= good_seen_next;
            since_init_reg <= since_init_next;
            quot_ok_reg    <= (pending_next == pending_reg);
        end
    end

endmodule

>>> hw/rtl/crr_out_buf.sv
// ----------------------------------------------------------------------------
// crr_out_buf
// two-entry result buffer: output register plus skid stage
// ----------------------------------------------------------------------------
module crr_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  crr_pkg::result_t push_data,
    output logic             can_push,
    output logic             out_valid,
    input  logic             out_ready,
    output crr_pkg::result_t out_data
);
    import crr_pkg::*;

    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;
    logic    pop;

    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign pop       = main_valid_reg && out_ready;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push && !main_valid_reg)
        begin
            main_reg <= push_data;
        end
        if (push && main_valid_reg && (!pop || skid_valid_reg))
        begin
            skid_reg <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                main_valid_reg <= skid_valid_reg || push;
                skid_valid_reg <= skid_valid_reg && push;
            end
            else if (push)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= main_valid_reg;
            end
        end
    end

endmodule

>>> hw/rtl/card_report_receiver_top.sv
// ----------------------------------------------------------------------------
// card_report_receiver_top
// checks an 80-byte card stream and tracks the card numbers to request
// ----------------------------------------------------------------------------
// One item per clock: a received byte, a start-report op or a request op each
// give one result item, computed in the accept cycle and held in a two-entry
// output buffer, so input keeps flowing while out_ready is low until it fills.
// The only bubble: a request op is held off in the cycle after an
// item that changed the request number, while the registered reciprocal
// multiply recomputes request / 23 for the block advance.
module card_report_receiver_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    input  logic        report_complete,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        card_done,
    output logic        card_good,
    output logic [7:0]  card_kind,
    output logic [15:0] expected_card,
    output logic [15:0] request_number,
    output logic        request_taken
);
    import crr_pkg::*;

    card_info_t info;
    result_t    result;
    result_t    out_data;
    logic       card_clear;
    logic       quot_ok;
    logic       can_push;
    logic       item_accept;

    assign in_ready    = can_push && (quot_ok || (op != OP_REQUEST));
    assign item_accept = in_valid && in_ready;

    crr_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (item_accept),
        .op          (op),
        .data_byte   (data_byte),
        .card_clear  (card_clear),
        .info        (info)
    );

    crr_seq u_seq
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_accept     (item_accept),
        .op              (op),
        .report_complete (report_complete),
        .info            (info),
        .card_clear      (card_clear),
        .quot_ok         (quot_ok),
        .result          (result)
    );

    crr_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_accept),
        .push_data (result),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign card_done      = out_data.card_done;
    assign card_good      = out_data.card_good;
    assign card_kind      = out_data.card_kind;
    assign expected_card  = out_data.expected_card;
    assign request_number = out_data.request_number;
    assign request_taken  = out_data.request_taken;

    // a taken request hands the old request number over as expected
    a_taken_expected: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && result.request_taken) |=>
            (u_seq.expected_reg == $past(u_seq.pending_reg)))
        else $error("request not handed over as expected number");

    a_good_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!card_good || card_done))
        else $error("good card flagged without card completion");

    a_done_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(card_done && request_taken))
        else $error("card completion and request in one item");

    a_request_quot: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && (op == OP_REQUEST)) |-> quot_ok)
        else $error("request accepted with stale quotient");

endmodule

>>> tb/sv/card_report_receiver_top_tb.sv
// ----------------------------------------------------------------------------
// card_report_receiver_top_tb
// self-checking bench for the card report receiver: checks cards and numbers
//
// Streams 80-byte cards and start/request ops into the block through a
// valid/ready channel with random gaps. A card tracker follows the header,
// type and number checks item by item. It predicts one result per accepted
// item and compares it field by field with what the block returns. A
// directed opening covers sign handling, overflow, a number that runs to the
// last byte of a card, cards dropped part way, requests before any card and
// requests after the report is complete. Random cards follow. About half of them
// are well formed and carry the expected number; the rest are broken or
// noise. The receiver stalls at random and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module card_report_receiver_top_tb;

    import crr_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         IDLE_PCT     = 32;
    localparam int         ITEM_COUNT   = 1400;
    localparam int         STEADY_START = 900;
    localparam int         STEADY_END   = 1150;
    localparam int         HOLD_START   = 1250;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         STALL_LIMIT  = 4000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         NUM_OFFSET   = 4;
    localparam int         MAX_REPORTS  = 30;

    localparam logic [7:0] GOOD_KINDS [5] = '{CH_A, CH_C, CH_D, CH_E, CH_NUL};

    typedef enum logic [1:0] {SKIP_SPACES, READ_DIGITS, PARSE_DONE} parse_phase_t;

    class card_tracker;
        logic [6:0]   byte_pos;
        bit           header_ok;
        logic [7:0]   kind_byte;
        parse_phase_t phase;
        bit           negative;
        int unsigned  value;
        int unsigned  expected_seq;
        int unsigned  pending_req;
        bit           good_seen;
        bit           card_since_init;
        result_t      due_results[$];
        int           errors;

        function new();
            clear_card();
            expected_seq    = INIT_EXPECTED;
            pending_req     = INIT_REQUEST;
            good_seen       = 1'b0;
            card_since_init = 1'b0;
            errors          = 0;
        endfunction

        function void clear_card();
            byte_pos  = '0;
            header_ok = 1'b1;
            kind_byte = CH_NUL;
            phase     = SKIP_SPACES;
            negative  = 1'b0;
            value     = 0;
        endfunction

        function void finish_card(ref result_t res);
            bit kind_ok;
            bit num_ok;
            kind_ok = kind_byte inside {CH_A, CH_C, CH_D, CH_E, CH_NUL};
            num_ok  = (value <= SEQ_MAX) && !(negative && value != 0) &&
                      (value == expected_seq);
            card_since_init = 1'b1;
            res.card_done   = 1'b1;
            res.card_kind   = kind_byte;
            if (header_ok && kind_ok && num_ok)
            begin
                if (kind_byte == CH_E && pending_req > expected_seq)
                    pending_req = expected_seq + 1;
                if (expected_seq < SEQ_MAX)
                    expected_seq++;
                good_seen     = 1'b1;
                res.card_good = 1'b1;
            end
            else if (pending_req > expected_seq)
            begin
                pending_req = expected_seq;
                if (good_seen && pending_req > 0)
                    pending_req--;
            end
            clear_card();
        endfunction

        function void accept_item(logic [1:0] code, logic [7:0] ch, logic complete);
            result_t     res;
            bit          take_digit;
            int unsigned next_req;
            res        = '0;
            take_digit = 1'b0;
            case (code)
                OP_BYTE:
                begin
                    if (byte_pos < 3)
                    begin
                        if (ch != ((byte_pos == 0) ? CH_O : CH_F))
                            header_ok = 1'b0;
                    end
                    else if (byte_pos == 3)
                        kind_byte = ch;
                    else
                    begin
                        if (phase == SKIP_SPACES)
                        begin
                            if (ch == CH_PLUS || ch == CH_MINUS)
                            begin
                                negative = (ch == CH_MINUS);
                                phase    = READ_DIGITS;
                            end
                            else if (ch != CH_SPACE)
                            begin
                                phase      = READ_DIGITS;
                                take_digit = 1'b1;
                            end
                        end
                        else if (phase == READ_DIGITS)
                            take_digit = 1'b1;
                        if (take_digit)
                        begin
                            if (ch >= CH_ZERO && ch <= CH_NINE)
                            begin
                                value = value * 10 + (ch - CH_ZERO);
                                if (value > VALUE_SAT)
                                    value = VALUE_SAT;
                            end
                            else
                                phase = PARSE_DONE;
                        end
                    end
                    byte_pos++;
                    if (byte_pos >= CARD_BYTES)
                        finish_card(res);
                end
                OP_INIT:
                begin
                    clear_card();
                    expected_seq    = INIT_EXPECTED;
                    pending_req     = INIT_REQUEST;
                    card_since_init = 1'b0;
                end
                OP_REQUEST:
                begin
                    if (card_since_init && !complete)
                    begin
                        next_req = (pending_req / BLOCK_CARDS + 1) * BLOCK_CARDS +
                                   BLOCK_OFFSET;
                        expected_seq = pending_req;
                        pending_req  = (next_req > SEQ_MAX) ? SEQ_MAX : next_req;
                        good_seen    = 1'b0;
                        clear_card();
                        res.request_taken = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            res.expected_card  = expected_seq[15:0];
            res.request_number = pending_req[15:0];
            due_results.push_back(res);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, got);
                return;
            end
            want = due_results.pop_front();
            compare_field("card_done", want.card_done, got.card_done);
            compare_field("card_good", want.card_good, got.card_good);
            compare_field("card_kind", want.card_kind, got.card_kind);
            compare_field("expected_card", want.expected_card, got.expected_card);
            compare_field("request_number", want.request_number, got.request_number);
            compare_field("request_taken", want.request_taken, got.request_taken);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic        report_complete;
    logic        out_valid;
    logic        out_ready;
    logic        card_done;
    logic        card_good;
    logic [7:0]  card_kind;
    logic [15:0] expected_card;
    logic [15:0] request_number;
    logic        request_taken;

    card_tracker tracker;
    bit          steady;
    bit          hold_request;
    int          items_sent;

    card_report_receiver_top dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .data_byte       (data_byte),
        .report_complete (report_complete),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .card_done       (card_done),
        .card_good       (card_good),
        .card_kind       (card_kind),
        .expected_card   (expected_card),
        .request_number  (request_number),
        .request_taken   (request_taken)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    task automatic send_item(input logic [1:0] code, input logic [7:0] ch,
                             input logic complete);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < IDLE_PCT);
        end
        in_valid        <= 1'b1;
        op              <= code;
        data_byte       <= ch;
        report_complete <= complete;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.accept_item(code, ch, complete);
        if (code != OP_UNUSED)
            items_sent++;
    endtask

    // nul sign means no sign byte; filler after the number is random
    task automatic send_card(input logic [7:0] kind, input int unsigned num,
                             input int spaces, input logic [7:0] sign,
                             input bit bad_header);
        logic [7:0] card [CARD_BYTES];
        string      digits;
        int         idx;
        int         pos;
        digits = $sformatf("%0d", num);
        for (idx = 0; idx < CARD_BYTES; idx++)
            card[idx] = 8'($urandom);
        card[0] = CH_O;
        card[1] = CH_F;
        card[2] = CH_F;
        card[3] = kind;
        if (bad_header)
        begin
            pos       = $urandom_range(0, 2);
            card[pos] = card[pos] ^ (8'd1 << $urandom_range(0, 7));
        end
        pos = NUM_OFFSET;
        for (idx = 0; idx < spaces && pos < CARD_BYTES; idx++)
        begin
            card[pos] = CH_SPACE;
            pos++;
        end
        if (sign != CH_NUL && pos < CARD_BYTES)
        begin
            card[pos] = sign;
            pos++;
        end
        for (idx = 0; idx < digits.len() && pos < CARD_BYTES; idx++)
        begin
            card[pos] = digits[idx];
            pos++;
        end
        if (pos < CARD_BYTES)
        begin
            do
                card[pos] = 8'($urandom);
            while (card[pos] >= CH_ZERO && card[pos] <= CH_NINE);
        end
        for (idx = 0; idx < CARD_BYTES; idx++)
            send_item(OP_BYTE, card[idx], 1'($urandom));
    endtask

    task automatic send_random_card();
        logic [7:0]  kind;
        int unsigned num;
        int          spaces;
        logic [7:0]  sign;
        bit          bad_header;
        int          flaw;
        string       digits;
        while (tracker.byte_pos != 0)
            send_item(OP_BYTE, 8'($urandom), 1'($urandom));
        kind       = GOOD_KINDS[$urandom_range(0, 4)];
        num        = tracker.expected_seq;
        spaces     = $urandom_range(0, 6);
        sign       = CH_NUL;
        bad_header = 1'b0;
        flaw       = $urandom_range(0, 11);
        case (flaw)
            0: bad_header = 1'b1;
            1: kind = 8'($urandom);
            2: num = num + $urandom_range(1, 3);
            3: num = num - 1;
            4: num = $urandom_range(65536, 999999);
            5: sign = CH_MINUS;
            default:
            begin
            end
        endcase
        if (flaw > 5)
        begin
            if ($urandom_range(0, 7) == 0)
                sign = CH_PLUS;
            else if (num == 0 && $urandom_range(0, 1) == 1)
                sign = CH_MINUS;
            if ($urandom_range(0, 9) == 0)
            begin
                digits = $sformatf("%0d", num);
                spaces = CARD_BYTES - NUM_OFFSET - digits.len();
            end
        end
        send_card(kind, num, spaces, sign, bad_header);
    endtask

    initial
    begin
        int  hold_left;
        result_t got;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.card_done      = card_done;
                got.card_good      = card_good;
                got.card_kind      = card_kind;
                got.expected_card  = expected_card;
                got.request_number = request_number;
                got.request_taken  = request_taken;
                tracker.check_result(got);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int  pick;
        int  burst;
        bit  hold_done;
        tracker         = new();
        steady          = 1'b0;
        hold_request    = 1'b0;
        hold_done       = 1'b0;
        items_sent      = 0;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        op              <= OP_BYTE;
        data_byte       <= 8'h00;
        report_complete <= 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ops with no card yet, then cards through each check
        send_item(OP_UNUSED, 8'hFF, 1'b1);
        send_item(OP_REQUEST, 8'h00, 1'b0);
        send_item(OP_INIT, 8'h00, 1'b0);
        send_card(CH_A, 1, 1, CH_NUL, 1'b0);
        send_card(CH_E, 2, 0, CH_PLUS, 1'b0);
        send_card(CH_D, 3, 3, CH_NUL, 1'b1);
        send_item(OP_REQUEST, 8'h00, 1'b1);
        send_item(OP_REQUEST, 8'h00, 1'b0);
        send_card(8'h42, 2, 0, CH_NUL, 1'b0);
        send_card(CH_NUL, 2, CARD_BYTES - NUM_OFFSET - 1, CH_NUL, 1'b0);
        send_card(CH_C, 32'hFFFF_FFFF, 0, CH_NUL, 1'b0);
        repeat (30)
            send_item(OP_BYTE, 8'($urandom), 1'b0);
        send_item(OP_INIT, 8'h00, 1'b1);
        send_card(CH_A, 5, 2, CH_MINUS, 1'b0);
        repeat (10)
            send_item(OP_BYTE, CH_SPACE, 1'b1);
        send_item(OP_REQUEST, 8'h00, 1'b0);
        send_card(CH_D, 0, 0, CH_MINUS, 1'b0);
        send_card(CH_E, 1, 5, CH_NUL, 1'b0);

        while (items_sent < ITEM_COUNT)
        begin
            steady = (items_sent >= STEADY_START && items_sent < STEADY_END);
            if (!hold_done && items_sent >= HOLD_START)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_random_card();
            else if (pick < 80)
                send_item(OP_REQUEST, 8'($urandom), $urandom_range(0, 4) == 0);
            else if (pick < 85)
                send_item(OP_INIT, 8'($urandom), 1'($urandom));
            else if (pick < 88)
                send_item(OP_UNUSED, 8'($urandom), 1'($urandom));
            else
            begin
                burst = $urandom_range(1, 40);
                repeat (burst)
                    send_item(OP_BYTE, 8'($urandom), 1'($urandom));
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (tracker.due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (tracker.errors == 0 && tracker.due_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
